// ===== design/rc4_stream_cipher_macros.svh =====
// assertion macros shared by the rc4 stream cipher rtl
`ifndef RC4_STREAM_CIPHER_MACROS_SVH
`define RC4_STREAM_CIPHER_MACROS_SVH

// same-cycle implication, disabled during reset
`define RC4_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rc4 assertion failed");

// next-cycle implication, disabled during reset
`define RC4_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rc4 assertion failed");

`endif

// ===== design/rc4_pkg.sv =====
// shared constants and types of the rc4 stream cipher
package rc4_pkg;

   localparam int TABLE_SIZE    = 256;
   localparam int MAX_KEY_BYTES = 32;
   localparam int BYTE_W        = 8;
   localparam int KEY_IDX_W     = $clog2(MAX_KEY_BYTES);
   localparam int KEY_LEN_W     = 6;
   localparam int KEY_WORDS     = 4;
   localparam int CSR_INDEX_W   = 3;
   localparam int CSR_DATA_W    = 64;

   // register indexes of the configuration port
   localparam logic [CSR_INDEX_W-1:0] CSR_KEY_LENGTH = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_KEY_WORD_0 = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_KEY_WORD_1 = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_KEY_WORD_2 = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_KEY_WORD_3 = 3'd4;

   // default key "defaultkey", byte 0 in the low bits
   localparam logic [KEY_LEN_W-1:0]  KEY_LENGTH_RESET = 6'd10;
   localparam logic [CSR_DATA_W-1:0] KEY_WORD_0_RESET = 64'h6b74_6c75_6166_6564;
   localparam logic [CSR_DATA_W-1:0] KEY_WORD_1_RESET = 64'h0000_0000_0000_7965;
   localparam logic [CSR_DATA_W-1:0] KEY_WORD_2_RESET = 64'h0;
   localparam logic [CSR_DATA_W-1:0] KEY_WORD_3_RESET = 64'h0;

   typedef logic [BYTE_W-1:0]    byte_type;
   typedef logic [KEY_IDX_W-1:0] key_idx_type;

   typedef struct packed {
      logic     en;
      byte_type addr;
      byte_type data;
   } ram_wr_type;

   typedef struct packed {
      key_idx_type last_idx;
      byte_type    key_byte;
   } key_info_type;

   typedef struct packed {
      logic     valid;
      byte_type data;
   } res_type;

endpackage

// ===== design/rc4_perm_ram.sv =====
// 256 x 8 permutation memory, one write port, one registered read port
module rc4_perm_ram (
   input  logic                clock,
   input  rc4_pkg::ram_wr_type wr,
   input  rc4_pkg::byte_type   rd_addr,
   output rc4_pkg::byte_type   rd_data
);
   import rc4_pkg::*;

   byte_type mem [TABLE_SIZE];
   byte_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/rc4_key_regs.sv =====
// key configuration registers and key byte selection
module rc4_key_regs (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_write_en,
   input  logic [rc4_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [rc4_pkg::CSR_DATA_W-1:0]       csr_write_data,
   input  rc4_pkg::key_idx_type                 key_idx,
   output rc4_pkg::key_info_type                key_info
);
   import rc4_pkg::*;

   logic [KEY_LEN_W-1:0]  key_length_ff;
   logic [CSR_DATA_W-1:0] key_word_ff [KEY_WORDS];
   key_idx_type           last_idx;

   always_ff @(posedge clock) begin
      if (reset) begin
         key_length_ff  <= KEY_LENGTH_RESET;
         key_word_ff[0] <= KEY_WORD_0_RESET;
         key_word_ff[1] <= KEY_WORD_1_RESET;
         key_word_ff[2] <= KEY_WORD_2_RESET;
         key_word_ff[3] <= KEY_WORD_3_RESET;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_KEY_LENGTH: key_length_ff  <= csr_write_data[KEY_LEN_W-1:0];
            CSR_KEY_WORD_0: key_word_ff[0] <= csr_write_data;
            CSR_KEY_WORD_1: key_word_ff[1] <= csr_write_data;
            CSR_KEY_WORD_2: key_word_ff[2] <= csr_write_data;
            CSR_KEY_WORD_3: key_word_ff[3] <= csr_write_data;
            default: ;
         endcase
      end
   end

   // zero length acts as one byte, long keys saturate
   always_comb begin
      if (key_length_ff == '0) begin
         last_idx = '0;
      end else if (key_length_ff > KEY_LEN_W'(MAX_KEY_BYTES)) begin
         last_idx = KEY_IDX_W'(MAX_KEY_BYTES - 1);
      end else begin
         last_idx = KEY_IDX_W'(key_length_ff - KEY_LEN_W'(1));
      end
   end

   assign key_info.last_idx = last_idx;
   assign key_info.key_byte = key_word_ff[key_idx[KEY_IDX_W-1:3]][{key_idx[2:0], 3'b000} +: BYTE_W];

endmodule

// ===== design/rc4_core.sv =====
// rc4 sequencer: table fill, key schedule and keystream generation
`include "rc4_stream_cipher_macros.svh"

module rc4_core (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_first_of_message,
   input  rc4_pkg::byte_type     req_data_byte,
   output logic                  req_ready,
   input  rc4_pkg::key_info_type key_info,
   output rc4_pkg::key_idx_type  key_idx,
   output rc4_pkg::ram_wr_type   ram_wr,
   output rc4_pkg::byte_type     ram_rd_addr,
   input  rc4_pkg::byte_type     ram_rd_data,
   output rc4_pkg::res_type      res,
   input  logic                  res_ready
);
   import rc4_pkg::*;

   typedef enum logic [3:0] {
      IDLE,
      FILL,
      KS_RD_N,
      KS_RD_A,
      KS_WR_N,
      KS_WR_A,
      PR_RD_I,
      PR_RD_J,
      PR_WR_I,
      PR_OUT
   } state_type;

   state_type   state_ff, state_in;
   byte_type    cnt_ff, cnt_in;
   byte_type    acc_ff, acc_in;
   key_idx_type kidx_ff, kidx_in;
   byte_type    i_ff, i_in;
   byte_type    j_ff, j_in;
   byte_type    sn_ff, sn_in;
   byte_type    sa_ff, sa_in;
   byte_type    t_ff, t_in;
   byte_type    data_ff, data_in;
   byte_type    ks;

   // keystream byte with the two swap writes forwarded
   always_comb begin
      if (t_ff == j_ff) begin
         ks = sn_ff;
      end else if (t_ff == i_ff) begin
         ks = sa_ff;
      end else begin
         ks = ram_rd_data;
      end
   end

   always_comb begin
      state_in    = state_ff;
      cnt_in      = cnt_ff;
      acc_in      = acc_ff;
      kidx_in     = kidx_ff;
      i_in        = i_ff;
      j_in        = j_ff;
      sn_in       = sn_ff;
      sa_in       = sa_ff;
      t_in        = t_ff;
      data_in     = data_ff;
      ram_wr      = '0;
      ram_rd_addr = cnt_ff;
      res         = '0;
      case (state_ff)
         IDLE: begin
            if (req_valid) begin
               data_in = req_data_byte;
               if (req_first_of_message) begin
                  cnt_in   = '0;
                  state_in = FILL;
               end else begin
                  i_in     = i_ff + 8'd1;
                  state_in = PR_RD_I;
               end
            end
         end
         FILL: begin
            ram_wr.en   = 1'b1;
            ram_wr.addr = cnt_ff;
            ram_wr.data = cnt_ff;
            cnt_in      = cnt_ff + 8'd1;
            if (cnt_ff == 8'hFF) begin
               acc_in   = '0;
               kidx_in  = '0;
               state_in = KS_RD_N;
            end
         end
         KS_RD_N: begin
            ram_rd_addr = cnt_ff;
            state_in    = KS_RD_A;
         end
         KS_RD_A: begin
            sn_in       = ram_rd_data;
            acc_in      = acc_ff + ram_rd_data + key_info.key_byte;
            ram_rd_addr = acc_in;
            state_in    = KS_WR_N;
         end
         KS_WR_N: begin
            ram_wr.en   = 1'b1;
            ram_wr.addr = cnt_ff;
            ram_wr.data = ram_rd_data;
            state_in    = KS_WR_A;
         end
         KS_WR_A: begin
            ram_wr.en   = 1'b1;
            ram_wr.addr = acc_ff;
            ram_wr.data = sn_ff;
            cnt_in      = cnt_ff + 8'd1;
            kidx_in     = (kidx_ff == key_info.last_idx) ? '0 : kidx_ff + 1'b1;
            if (cnt_ff == 8'hFF) begin
               i_in     = 8'd1;
               j_in     = '0;
               state_in = PR_RD_I;
            end else begin
               state_in = KS_RD_N;
            end
         end
         PR_RD_I: begin
            ram_rd_addr = i_ff;
            state_in    = PR_RD_J;
         end
         PR_RD_J: begin
            sn_in       = ram_rd_data;
            j_in        = j_ff + ram_rd_data;
            ram_rd_addr = j_in;
            state_in    = PR_WR_I;
         end
         PR_WR_I: begin
            sa_in       = ram_rd_data;
            ram_wr.en   = 1'b1;
            ram_wr.addr = i_ff;
            ram_wr.data = ram_rd_data;
            t_in        = sn_ff + ram_rd_data;
            ram_rd_addr = t_in;
            state_in    = PR_OUT;
         end
         PR_OUT: begin
            ram_wr.en   = 1'b1;
            ram_wr.addr = j_ff;
            ram_wr.data = sn_ff;
            ram_rd_addr = t_ff;
            res.valid   = 1'b1;
            res.data    = data_ff ^ ks;
            if (res_ready) begin
               state_in = IDLE;
            end
         end
         default: begin
            state_in = IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE;
         i_ff     <= '0;
         j_ff     <= '0;
      end else begin
         state_ff <= state_in;
         i_ff     <= i_in;
         j_ff     <= j_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff  <= cnt_in;
      acc_ff  <= acc_in;
      kidx_ff <= kidx_in;
      sn_ff   <= sn_in;
      sa_ff   <= sa_in;
      t_ff    <= t_in;
      data_ff <= data_in;
   end

   assign req_ready = (state_ff == IDLE);
   assign key_idx   = kidx_ff;

   `RC4_ASSERT_IMPL(a_idle_no_write, clock, reset, state_ff == IDLE, !ram_wr.en)
   `RC4_ASSERT_NEXT(a_data_step_i, clock, reset, state_ff == IDLE && req_valid && !req_first_of_message, state_ff == PR_RD_I && i_ff == 8'($past(i_ff) + 8'd1))
   `RC4_ASSERT_NEXT(a_ks_done_idx, clock, reset, state_ff == KS_WR_A && cnt_ff == 8'hFF, state_ff == PR_RD_I && i_ff == 8'd1 && j_ff == 8'd0)

endmodule

// ===== design/rc4_stream_cipher.sv =====
// top level of the rc4 stream cipher with its output register
//
// usage
//   req channel: one transaction carries a data byte and a first_of_message
//   flag; rsp channel: one transaction carries the byte xor keystream, one
//   per request, in order. both channels use valid and ready
//   csr port: key_length (index 0) and key words 0..3 (indexes 1..4), written
//   while the block is idle; the key takes effect at the next first byte
//   sequencing
//   a data byte steps through the accepting state, read i, read j, write i
//   with the keystream read, and write j with the result; the next byte is
//   taken only after the sequencer has handed this result on
//   a first byte first rebuilds the table: identity fill, then key schedule
//   reads and swaps, one memory read and write per cycle
//   reset
//   indices clear, the key returns to the default "defaultkey"; the table
//   is undefined until the first first_of_message transaction
//   stall
//   the output register holds one result; the next request is taken while
//   it waits, and the sequencer holds its last step until the register frees
`include "rc4_stream_cipher_macros.svh"

module rc4_stream_cipher (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic                            req_first_of_message,
   input  logic [7:0]                      req_data_byte,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [7:0]                      rsp_out_byte,
   input  logic                            csr_write_en,
   input  logic [rc4_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [rc4_pkg::CSR_DATA_W-1:0]  csr_write_data
);
   import rc4_pkg::*;

   key_info_type key_info;
   key_idx_type  key_idx;
   ram_wr_type   ram_wr;
   byte_type     ram_rd_addr;
   byte_type     ram_rd_data;
   res_type      res;
   logic         res_ready;

   // output register state
   logic     out_valid_ff, out_valid_in;
   byte_type out_byte_ff;

   // key registers and key byte select
   rc4_key_regs u_key_regs (
      .clock          (clock),
      .reset          (reset),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data),
      .key_idx        (key_idx),
      .key_info       (key_info)
   );

   // permutation table memory
   rc4_perm_ram u_perm_ram (
      .clock   (clock),
      .wr      (ram_wr),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // sequencer for fill, key schedule and keystream
   rc4_core u_core (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_first_of_message (req_first_of_message),
      .req_data_byte        (req_data_byte),
      .req_ready            (req_ready),
      .key_info             (key_info),
      .key_idx              (key_idx),
      .ram_wr               (ram_wr),
      .ram_rd_addr          (ram_rd_addr),
      .ram_rd_data          (ram_rd_data),
      .res                  (res),
      .res_ready            (res_ready)
   );

   // register is free when empty or being drained this cycle
   assign res_ready = !out_valid_ff || rsp_ready;

   always_comb begin
      out_valid_in = out_valid_ff;
      if (res.valid && res_ready) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   // payload of the output register
   always_ff @(posedge clock) begin
      if (res.valid && res_ready) begin
         out_byte_ff <= res.data;
      end
   end

   assign rsp_valid    = out_valid_ff;
   assign rsp_out_byte = out_byte_ff;

   `RC4_ASSERT_NEXT(a_result_loaded, clock, reset, res.valid && res_ready,
                    rsp_valid && rsp_out_byte == $past(res.data))

endmodule

// ===== bench/rc4_cipher_checker.sv =====
// scoreboard for the rc4 stream cipher: tracks the key, predicts each output byte and compares
module rc4_cipher_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   input  logic                            req_ready,
   input  logic                            req_first_of_message,
   input  logic [7:0]                      req_data_byte,
   input  logic                            rsp_valid,
   input  logic                            rsp_ready,
   input  logic [7:0]                      rsp_out_byte,
   input  logic                            csr_write_en,
   input  logic [rc4_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [rc4_pkg::CSR_DATA_W-1:0]  csr_write_data,
   output int                              mismatch_count,
   output int                              pending_results,
   output int                              results_checked
);
   import rc4_pkg::*;

   localparam int REPORT_LIMIT = 100;

   byte_type              perm [TABLE_SIZE];
   byte_type              idx_i;
   byte_type              idx_j;
   logic [KEY_LEN_W-1:0]  key_len;
   logic [CSR_DATA_W-1:0] key_word [KEY_WORDS];
   byte_type              expected_bytes [$];
   byte_type              want;
   int                    errors = 0;
   int                    checked = 0;

   task automatic report_mismatch(input string msg);
      if (errors < REPORT_LIMIT) begin
         $display("[%0t] mismatch: %s", $time, msg);
      end
      errors++;
   endtask

   // identity fill, then the key schedule over the repeating key
   function automatic void rebuild_perm();
      int unsigned klen;
      int unsigned kpos;
      int          n;
      byte_type    acc;
      byte_type    tmp;
      klen = 32'(key_len);
      if (klen < 1) klen = 1;
      if (klen > MAX_KEY_BYTES) klen = MAX_KEY_BYTES;
      for (n = 0; n < TABLE_SIZE; n++) perm[n] = byte_type'(n);
      acc = '0;
      for (n = 0; n < TABLE_SIZE; n++) begin
         kpos = n % klen;
         acc = acc + perm[n] + key_word[kpos / 8][(kpos % 8) * 8 +: 8];
         tmp = perm[n];
         perm[n] = perm[acc];
         perm[acc] = tmp;
      end
      idx_i = '0;
      idx_j = '0;
   endfunction

   function automatic byte_type next_cipher_byte(input logic first, input byte_type data);
      byte_type tmp;
      byte_type ks_addr;
      if (first) rebuild_perm();
      idx_i = idx_i + 8'd1;
      idx_j = idx_j + perm[idx_i];
      tmp = perm[idx_i];
      perm[idx_i] = perm[idx_j];
      perm[idx_j] = tmp;
      ks_addr = perm[idx_i] + perm[idx_j];
      return data ^ perm[ks_addr];
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         key_len     = KEY_LENGTH_RESET;
         key_word[0] = KEY_WORD_0_RESET;
         key_word[1] = KEY_WORD_1_RESET;
         key_word[2] = KEY_WORD_2_RESET;
         key_word[3] = KEY_WORD_3_RESET;
         idx_i       = '0;
         idx_j       = '0;
         foreach (perm[n]) perm[n] = '0;
         expected_bytes.delete();
      end else begin
         if (csr_write_en) begin
            case (csr_index)
               CSR_KEY_LENGTH: key_len     = csr_write_data[KEY_LEN_W-1:0];
               CSR_KEY_WORD_0: key_word[0] = csr_write_data;
               CSR_KEY_WORD_1: key_word[1] = csr_write_data;
               CSR_KEY_WORD_2: key_word[2] = csr_write_data;
               CSR_KEY_WORD_3: key_word[3] = csr_write_data;
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            expected_bytes.push_back(next_cipher_byte(req_first_of_message, req_data_byte));
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_bytes.size() == 0) begin
               report_mismatch($sformatf("output byte %02h with nothing outstanding",
                                         rsp_out_byte));
            end else begin
               want = expected_bytes.pop_front();
               checked++;
               if (rsp_out_byte !== want) begin
                  report_mismatch($sformatf("out_byte %02h, predicted %02h (result %0d)",
                                            rsp_out_byte, want, checked));
               end
            end
         end
      end
      mismatch_count  <= errors;
      pending_results <= expected_bytes.size();
      results_checked <= checked;
   end

endmodule

// ===== bench/tb.sv =====
// top of the rc4 stream cipher testbench: clock, reset, stimulus and verdict
module tb;
   import rc4_pkg::*;

   localparam int CLK_PERIOD      = 12;
   localparam int PHASES          = 8;
   localparam int PHASE_ITEMS     = 120;
   localparam int LONG_MESSAGE    = 300;
   localparam int HOLD_OFF_CYCLES = 400;
   localparam int DRAIN_CYCLES    = 16;
   // worst case is one key schedule plus stalls; this is many times that
   localparam int TIMEOUT_CYCLES  = 2_000_000;

   // unmapped register indexes, writes there must leave the key alone
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_LO = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_HI = 3'd7;

   // one bit per register index
   localparam logic [4:0] ALL_KEY_REGS    = 5'b11111;
   localparam logic [4:0] KEY_LENGTH_ONLY = 5'b00001;

   typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_type;

   logic                   clock                = 1'b0;
   logic                   reset                = 1'b1;
   logic                   req_valid            = 1'b0;
   logic                   req_ready;
   logic                   req_first_of_message = 1'b0;
   logic [7:0]             req_data_byte        = '0;
   logic                   rsp_valid;
   logic                   rsp_ready            = 1'b0;
   logic [7:0]             rsp_out_byte;
   logic                   csr_write_en         = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index            = '0;
   logic [CSR_DATA_W-1:0]  csr_write_data       = '0;

   int mismatch_count;
   int pending_results;
   int results_checked;

   // knobs shared between the stimulus and the receiver process
   int idle_pct      = 0;
   int stall_pct     = 0;
   // the stimulus bumps the request count, the receiver counts the hold-off down
   int hold_requests = 0;
   int hold_cycles   = 0;

   // run statistics for the summary
   int bytes_sent    = 0;
   int messages_sent = 0;
   int key_loads     = 0;

   idle_mode_type mode;
   int            phase;
   int            in_phase;
   int            left;
   logic          first_flag;

   rc4_stream_cipher dut (.*);

   rc4_cipher_checker checker_inst (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_first_of_message (req_first_of_message),
      .req_data_byte        (req_data_byte),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_out_byte         (rsp_out_byte),
      .csr_write_en         (csr_write_en),
      .csr_index            (csr_index),
      .csr_write_data       (csr_write_data),
      .mismatch_count       (mismatch_count),
      .pending_results      (pending_results),
      .results_checked      (results_checked)
   );

   always begin
      #(CLK_PERIOD / 2) clock = 1'b1;
      #(CLK_PERIOD / 2) clock = 1'b0;
   end

   // hard stop in case the block hangs
   initial begin
      #(TIMEOUT_CYCLES * CLK_PERIOD);
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // result side: a long hold-off when asked, otherwise random stalls at stall_pct
   initial begin
      int holds_served;
      holds_served = 0;
      forever begin
         @(negedge clock);
         if (holds_served != hold_requests) begin
            holds_served = hold_requests;
            hold_cycles  = HOLD_OFF_CYCLES;
         end
         if (hold_cycles > 0) begin
            rsp_ready <= 1'b0;
            hold_cycles--;
         end else begin
            rsp_ready <= ($urandom_range(99) >= stall_pct);
         end
      end
   end

   // one transaction on the request side, called and returning at a falling edge
   task automatic send_byte(input logic first, input logic [7:0] data);
      // random gap before the transaction, valid drops only between items
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid            <= 1'b1;
      req_first_of_message <= first;
      req_data_byte        <= data;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
      bytes_sent++;
      if (first) messages_sent++;
   endtask

   task automatic send_random(input int count, input logic first);
      int k;
      for (k = 0; k < count; k++) begin
         send_byte(first && (k == 0), 8'($urandom_range(255)));
      end
   endtask

   // stop offering and wait until every predicted byte has come back
   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_results != 0 || hold_cycles != 0) @(posedge clock);
      @(negedge clock);
   endtask

   // leaves the write enable high, the caller lowers it after its last write
   task automatic csr_write(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      csr_write_en   <= 1'b1;
      csr_index      <= idx;
      csr_write_data <= data;
      @(negedge clock);
   endtask

   task automatic load_key(input logic [CSR_DATA_W-1:0] len_word,
                           input logic [CSR_DATA_W-1:0] w0,
                           input logic [CSR_DATA_W-1:0] w1,
                           input logic [CSR_DATA_W-1:0] w2,
                           input logic [CSR_DATA_W-1:0] w3,
                           input logic [4:0] mask);
      if (mask[CSR_KEY_LENGTH]) csr_write(CSR_KEY_LENGTH, len_word);
      if (mask[CSR_KEY_WORD_0]) csr_write(CSR_KEY_WORD_0, w0);
      if (mask[CSR_KEY_WORD_1]) csr_write(CSR_KEY_WORD_1, w1);
      if (mask[CSR_KEY_WORD_2]) csr_write(CSR_KEY_WORD_2, w2);
      if (mask[CSR_KEY_WORD_3]) csr_write(CSR_KEY_WORD_3, w3);
      csr_write_en <= 1'b0;
      key_loads++;
   endtask

   // random key, length biased toward the extremes and the saturating range
   task automatic load_random_key();
      logic [CSR_DATA_W-1:0] len_word;
      logic [4:0]            mask;
      len_word = {$urandom, $urandom};
      case ($urandom_range(7))
         0:       len_word[KEY_LEN_W-1:0] = '0;
         1:       len_word[KEY_LEN_W-1:0] = KEY_LEN_W'($urandom_range(33, 63));
         2:       len_word[KEY_LEN_W-1:0] = KEY_LEN_W'(MAX_KEY_BYTES);
         3:       len_word[KEY_LEN_W-1:0] = KEY_LEN_W'(1);
         default: len_word[KEY_LEN_W-1:0] = KEY_LEN_W'($urandom_range(1, 32));
      endcase
      // usually the whole key, sometimes only some registers
      mask = ($urandom_range(3) == 0) ? 5'($urandom) : ALL_KEY_REGS;
      load_key(len_word, {$urandom, $urandom}, {$urandom, $urandom},
               {$urandom, $urandom}, {$urandom, $urandom}, mask);
   endtask

   // mostly short messages, now and then a long one that may wrap the indices
   function automatic int message_length();
      if ($urandom_range(11) == 0) return $urandom_range(100, LONG_MESSAGE);
      return $urandom_range(1, 24);
   endfunction

   initial begin
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // ---- directed part, no idling ----
      // default key after reset, data extremes; the table is built before any data
      send_byte(1'b1, 8'h00);
      send_byte(1'b0, 8'hff);
      send_byte(1'b0, 8'h55);
      send_byte(1'b0, 8'haa);
      send_byte(1'b0, 8'h01);
      send_byte(1'b0, 8'h80);
      // one-byte messages back to back
      send_byte(1'b1, 8'hff);
      send_byte(1'b1, 8'h00);

      // key length zero acts as one, upper data bits ignored, spare indexes inert
      wait_idle();
      csr_write(CSR_SPARE_LO, '1);
      csr_write(CSR_SPARE_HI, '1);
      load_key(64'hffff_ffff_ffff_ffc0, 64'h0123_4567_89ab_cdef, 64'hfedc_ba98_7654_3210,
               '1, '0, ALL_KEY_REGS);
      send_random(3, 1'b1);

      // full 32-byte key of all ones
      wait_idle();
      load_key(64'd32, '1, '1, '1, '1, ALL_KEY_REGS);
      send_random(3, 1'b1);

      // length above the maximum saturates, all-zero key
      wait_idle();
      load_key(64'd63, '0, '0, '0, '0, ALL_KEY_REGS);
      send_random(3, 1'b1);

      // only the length changes, key words kept from before
      wait_idle();
      load_key(64'd1, '0, '0, '0, '0, KEY_LENGTH_ONLY);
      send_random(3, 1'b1);

      // new key written mid-message only counts from the next first byte
      wait_idle();
      load_key(64'd16, {$urandom, $urandom}, {$urandom, $urandom}, '0, '0, ALL_KEY_REGS);
      send_random(2, 1'b1);
      wait_idle();
      load_random_key();
      send_random(2, 1'b0);
      send_byte(1'b1, 8'($urandom_range(255)));

      // ---- random part, idle mixes rotate per phase ----
      for (phase = 0; phase < PHASES; phase++) begin
         wait_idle();
         mode = idle_mode_type'(phase % 4);
         case (mode)
            IDLE_NONE:     begin idle_pct = 0;  stall_pct = 0;  end
            IDLE_SENDER:   begin idle_pct = 88; stall_pct = 0;  end
            IDLE_RECEIVER: begin idle_pct = 0;  stall_pct = 88; end
            default:       begin idle_pct = 15; stall_pct = 15; end
         endcase
         load_random_key();
         // sometimes keep the running message going under the new key
         left = (phase > 0 && $urandom_range(2) == 0) ? $urandom_range(1, 8) : 0;
         first_flag = 1'b0;
         in_phase = 0;
         // finish the message in progress even past the phase budget
         while (in_phase < PHASE_ITEMS || left != 0) begin
            if (left == 0) begin
               left = (phase == 0 && in_phase == 0) ? LONG_MESSAGE : message_length();
               first_flag = 1'b1;
            end
            // long receiver hold-off while requests keep coming, fills the block
            if (mode == IDLE_NONE && in_phase == 60) hold_requests++;
            send_byte(first_flag, 8'($urandom_range(255)));
            first_flag = 1'b0;
            left--;
            in_phase++;
         end
      end

      wait_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d bytes in %0d messages under %0d key loads, %0d results checked",
               bytes_sent, messages_sent, key_loads, results_checked);
      $display("key lengths 0 to 63, index wrap past 256 bytes, key swaps mid-message");
      if (mismatch_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
